[sv/tmi_pkg.sv]
// Shared constants, codes and interface types of the tape machine interpreter core.
package tmi_pkg;

   localparam int CODE_DEPTH  = 4096;
   localparam int TAPE_DEPTH  = 32768;
   localparam int STACK_DEPTH = 64;

   localparam int CODE_AW  = $clog2(CODE_DEPTH);
   localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int STACK_LW = $clog2(STACK_DEPTH + 1);

   localparam int PC_W    = 13;
   localparam int CADDR_W = 12;
   localparam int BYTE_W  = 8;
   localparam int CHAR_W  = 7;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SKIP,
      ST_HOLD
   } seq_state_type;

   typedef struct packed {
      logic inc;
      logic dec;
      logic right;
      logic left;
   } tape_ctl_type;

   typedef struct packed {
      logic              busy;
      logic [BYTE_W-1:0] data;
   } tape_stat_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic               clear;
      logic [CODE_AW-1:0] pos;
   } stack_ctl_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [CODE_AW-1:0] top;
   } stack_stat_type;

endpackage

[sv/tmi_code_store.sv]
// Code store: synchronous program memory with one write port and one registered read port.
module tmi_code_store (
   input  logic                        clock,
   input  logic                        we,
   input  logic [tmi_pkg::CADDR_W-1:0] waddr,
   input  logic [tmi_pkg::BYTE_W-1:0]  wdata,
   input  logic [tmi_pkg::PC_W-1:0]    raddr,
   output logic [tmi_pkg::BYTE_W-1:0]  rdata,
   output logic                        rd_oob
);
   import tmi_pkg::*;

   logic [BYTE_W-1:0] mem_ff [CODE_DEPTH];
   logic [BYTE_W-1:0] rd_ff;
   logic              oob_ff;

   always_ff @(posedge clock) begin
      if (we && (32'(waddr) < CODE_DEPTH)) begin
         mem_ff[CODE_AW'(waddr)] <= wdata;
      end
      rd_ff  <= mem_ff[CODE_AW'(raddr)];
      oob_ff <= (32'(raddr) >= CODE_DEPTH);
   end

   assign rdata  = rd_ff;
   assign rd_oob = oob_ff;

endmodule

[sv/tmi_tape.sv]
// Tape: cell memory with head register, cell update and the clearing sweep after reset.
module tmi_tape (
   input  logic                  clock,
   input  logic                  reset,
   input  tmi_pkg::tape_ctl_type ctl,
   output tmi_pkg::tape_stat_type stat
);
   import tmi_pkg::*;

   logic [BYTE_W-1:0]  mem_ff [TAPE_DEPTH];
   logic [BYTE_W-1:0]  rd_ff;
   logic [TAPE_AW-1:0] head_ff, head_in;
   logic [TAPE_AW-1:0] clr_ff, clr_in;
   logic               busy_ff, busy_in;
   logic               we;
   logic [TAPE_AW-1:0] waddr;
   logic [BYTE_W-1:0]  wdata;

   always_comb begin
      head_in = head_ff;
      clr_in  = clr_ff;
      busy_in = busy_ff;
      we      = 1'b0;
      waddr   = head_ff;
      wdata   = rd_ff;
      if (busy_ff) begin
         we     = 1'b1;
         waddr  = clr_ff;
         wdata  = '0;
         clr_in = clr_ff + 1'b1;
         if (clr_ff == TAPE_AW'(TAPE_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end else begin
         if (ctl.inc) begin
            we    = 1'b1;
            wdata = rd_ff + 1'b1;
         end else if (ctl.dec) begin
            we    = 1'b1;
            wdata = rd_ff - 1'b1;
         end
         if (ctl.right) begin
            head_in = (head_ff == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end else if (ctl.left) begin
            head_in = (head_ff == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : head_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         head_ff <= head_in;
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[head_ff];
   end

   assign stat.busy = busy_ff;
   assign stat.data = rd_ff;

endmodule

[sv/tmi_loop_stack.sv]
// Loop stack: memory of open bracket positions with its level counter and registered top read.
module tmi_loop_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  tmi_pkg::stack_ctl_type  ctl,
   output tmi_pkg::stack_stat_type stat
);
   import tmi_pkg::*;

   logic [CODE_AW-1:0]  mem_ff [STACK_DEPTH];
   logic [CODE_AW-1:0]  top_ff;
   logic [STACK_LW-1:0] level_ff, level_in;
   logic [STACK_LW-1:0] level_dec;

   assign level_dec = level_ff - 1'b1;

   always_comb begin
      level_in = level_ff;
      if (ctl.clear) begin
         level_in = '0;
      end else if (ctl.push) begin
         level_in = level_ff + 1'b1;
      end else if (ctl.pop) begin
         level_in = level_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clear) begin
         mem_ff[level_ff[STACK_AW-1:0]] <= ctl.pos;
      end
      top_ff <= mem_ff[level_dec[STACK_AW-1:0]];
   end

   assign stat.empty = (level_ff == '0);
   assign stat.full  = (level_ff == STACK_LW'(STACK_DEPTH));
   assign stat.top   = top_ff;

endmodule

[sv/tmi_sequencer.sv]
// Sequencer: instruction decode, program counter, bracket skip scan and result register.
module tmi_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tmi_pkg::OP_W-1:0]     req_op,
   input  logic [tmi_pkg::CADDR_W-1:0]  req_code_addr,
   input  logic [tmi_pkg::BYTE_W-1:0]   req_code_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_out_valid,
   output logic [tmi_pkg::CHAR_W-1:0]   rsp_out_char,
   output logic                         rsp_halted,
   output logic                         rsp_stack_overflow,
   input  logic                         csr_write,
   input  logic [tmi_pkg::PC_W-1:0]     csr_wdata,
   output logic                         code_we,
   output logic [tmi_pkg::CADDR_W-1:0]  code_waddr,
   output logic [tmi_pkg::BYTE_W-1:0]   code_wdata,
   output logic [tmi_pkg::PC_W-1:0]     code_raddr,
   input  logic [tmi_pkg::BYTE_W-1:0]   code_rdata,
   input  logic                         code_oob,
   output tmi_pkg::tape_ctl_type        tape_ctl,
   input  tmi_pkg::tape_stat_type       tape_stat,
   output tmi_pkg::stack_ctl_type       stack_ctl,
   input  tmi_pkg::stack_stat_type      stack_stat
);
   import tmi_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [PC_W-1:0]    len_ff;
   logic [PC_W-1:0]    scan_ff, scan_in;
   logic [PC_W-1:0]    depth_ff, depth_in;
   logic [OP_W-1:0]    op_ff;
   logic [CADDR_W-1:0] addr_ff;
   logic [BYTE_W-1:0]  byte_ff;
   logic               pend_valid_ff;
   logic [CHAR_W-1:0]  pend_char_ff;
   logic               pend_ovf_ff;
   logic               rsp_valid_ff;
   logic               rsp_out_valid_ff;
   logic [CHAR_W-1:0]  rsp_out_char_ff;
   logic               rsp_halted_ff;
   logic               rsp_ovf_ff;
   logic               accept;
   logic               fin;
   logic               out_free;
   logic               out_load;
   logic               res_valid;
   logic [CHAR_W-1:0]  res_char;
   logic               res_ovf;
   logic [BYTE_W-1:0]  code_c;
   logic [BYTE_W-1:0]  tape_byte;
   logic               run;

   assign code_c    = code_oob ? '0 : code_rdata;
   assign tape_byte = tape_stat.data;
   assign run       = (op_ff == OP_STEP) && (pc_ff < len_ff);
   assign req_stall = (state_ff != ST_IDLE) || tape_stat.busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign code_we    = (state_ff == ST_EXEC) && (op_ff == OP_LOAD);
   assign code_waddr = addr_ff;
   assign code_wdata = byte_ff;

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      scan_in    = scan_ff;
      depth_in   = depth_ff;
      code_raddr = pc_ff;
      tape_ctl   = '0;
      stack_ctl  = '0;
      stack_ctl.pos = CODE_AW'(pc_ff);
      fin        = 1'b0;
      res_valid  = 1'b0;
      res_char   = '0;
      res_ovf    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            fin = 1'b1;
            if (op_ff == OP_RESTART) begin
               pc_in           = '0;
               stack_ctl.clear = 1'b1;
            end else if (run) begin
               pc_in = pc_ff + 1'b1;
               case (code_c)
                  CH_PLUS:  tape_ctl.inc   = 1'b1;
                  CH_MINUS: tape_ctl.dec   = 1'b1;
                  CH_RIGHT: tape_ctl.right = 1'b1;
                  CH_LEFT:  tape_ctl.left  = 1'b1;
                  CH_DOT: begin
                     if (!tape_byte[BYTE_W-1] && (tape_byte >= CH_SPACE)) begin
                        res_valid = 1'b1;
                        res_char  = tape_byte[CHAR_W-1:0];
                     end
                  end
                  CH_OPEN: begin
                     if (tape_byte == '0) begin
                        fin        = 1'b0;
                        state_in   = ST_SKIP;
                        scan_in    = pc_ff + 1'b1;
                        depth_in   = '0;
                        code_raddr = pc_ff + 1'b1;
                     end else if (!stack_stat.full) begin
                        stack_ctl.push = 1'b1;
                     end else begin
                        res_ovf = 1'b1;
                     end
                  end
                  CH_CLOSE: begin
                     if (!stack_stat.empty) begin
                        if (tape_byte == '0) begin
                           stack_ctl.pop = 1'b1;
                        end else begin
                           pc_in = PC_W'(stack_stat.top) + 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SKIP: begin
            code_raddr = scan_ff + 1'b1;
            scan_in    = scan_ff + 1'b1;
            if (scan_ff >= len_ff) begin
               pc_in = len_ff;
               fin   = 1'b1;
            end else if (code_c == CH_OPEN) begin
               depth_in = depth_ff + 1'b1;
            end else if (code_c == CH_CLOSE) begin
               if (depth_ff == '0) begin
                  pc_in = scan_ff + 1'b1;
                  fin   = 1'b1;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
            end
         end
         ST_HOLD: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      out_load = out_free && (fin || (state_ff == ST_HOLD));
      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end else if ((state_ff == ST_HOLD) && out_free) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (csr_write) begin
            len_ff <= csr_wdata;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      depth_ff <= depth_in;
      if (accept) begin
         op_ff   <= req_op;
         addr_ff <= req_code_addr;
         byte_ff <= req_code_byte;
      end
      if (fin && !out_free) begin
         pend_valid_ff <= res_valid;
         pend_char_ff  <= res_char;
         pend_ovf_ff   <= res_ovf;
      end
      if (out_load) begin
         rsp_out_valid_ff <= fin ? res_valid : pend_valid_ff;
         rsp_out_char_ff  <= fin ? res_char  : pend_char_ff;
         rsp_ovf_ff       <= fin ? res_ovf   : pend_ovf_ff;
         rsp_halted_ff    <= (pc_in >= len_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_valid      = rsp_out_valid_ff;
   assign rsp_out_char       = rsp_out_char_ff;
   assign rsp_halted         = rsp_halted_ff;
   assign rsp_stack_overflow = rsp_ovf_ff;

endmodule

[sv/tape_machine_interpreter_core_top.sv]
// Top level of the tape machine interpreter core.
//
// The request channel (req_valid, req_stall) carries one transaction per item: op 0 loads
// req_code_byte at req_code_addr, op 1 executes one instruction, op 2 restarts at the start
// of the program with an empty loop stack. Every transaction produces exactly one response
// transaction on rsp_valid/rsp_stall with the print flag, character, halted and overflow flags.
// The csr channel writes program_length; it is always ready. Use it only while idle: the block
// itself does not enforce this. The accepting edge also issues the registered code, tape and
// stack reads; ST_EXEC then executes, writes back and loads the response register if it is free,
// else the result waits in ST_HOLD. An open bracket on a zero cell scans the code store one
// position per cycle in ST_SKIP, up to and including its matching close (or up to program_length).
// A new transaction is accepted only once the previous one has finished and the core is idle.
// After reset the tape memory is cleared, one cell per cycle, across all 32768 cells; req_stall
// is high during that sweep. A finished result waits in the response register while
// rsp_stall is high; one further result can be held inside, after which req_stall stays high.
module tape_machine_interpreter_core_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tmi_pkg::OP_W-1:0]    req_op,
   input  logic [tmi_pkg::CADDR_W-1:0] req_code_addr,
   input  logic [tmi_pkg::BYTE_W-1:0]  req_code_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_out_valid,
   output logic [tmi_pkg::CHAR_W-1:0]  rsp_out_char,
   output logic                        rsp_halted,
   output logic                        rsp_stack_overflow,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tmi_pkg::PC_W-1:0]    csr_wdata
);
   import tmi_pkg::*;

   logic               code_we;
   logic [CADDR_W-1:0] code_waddr;
   logic [BYTE_W-1:0]  code_wdata;
   logic [PC_W-1:0]    code_raddr;
   logic [BYTE_W-1:0]  code_rdata;
   logic               code_oob;
   tape_ctl_type       tape_ctl;
   tape_stat_type      tape_stat;
   stack_ctl_type      stack_ctl;
   stack_stat_type     stack_stat;

   assign csr_ready = 1'b1;

   tmi_code_store u_code_store (
      .clock  (clock),
      .we     (code_we),
      .waddr  (code_waddr),
      .wdata  (code_wdata),
      .raddr  (code_raddr),
      .rdata  (code_rdata),
      .rd_oob (code_oob)
   );

   tmi_tape u_tape (
      .clock (clock),
      .reset (reset),
      .ctl   (tape_ctl),
      .stat  (tape_stat)
   );

   tmi_loop_stack u_loop_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stack_ctl),
      .stat  (stack_stat)
   );

   tmi_sequencer u_sequencer (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_code_addr      (req_code_addr),
      .req_code_byte      (req_code_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_char       (rsp_out_char),
      .rsp_halted         (rsp_halted),
      .rsp_stack_overflow (rsp_stack_overflow),
      .csr_write          (csr_valid && csr_ready),
      .csr_wdata          (csr_wdata),
      .code_we            (code_we),
      .code_waddr         (code_waddr),
      .code_wdata         (code_wdata),
      .code_raddr         (code_raddr),
      .code_rdata         (code_rdata),
      .code_oob           (code_oob),
      .tape_ctl           (tape_ctl),
      .tape_stat          (tape_stat),
      .stack_ctl          (stack_ctl),
      .stack_stat         (stack_stat)
   );

endmodule
